// File: rtl/core/hnso_pkg.sv
// Package for the hashed noise shake offset block.
// Holds the fraction width, hash constants and pipeline step counts.
// Depends on nothing; used by hashed_noise_shake_offset_top.
package hnso_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 16;

  localparam logic [31:0] HASH_MUL = 32'd747796405;
  localparam logic [31:0] HASH_ADD = 32'd2891336453;
  localparam logic [31:0] HASH_MIX = 32'd277803737;

endpackage

// File: rtl/core/hashed_noise_shake_offset_top.sv
// Top level of the hashed noise shake offset block.
// Fully pipelined hash, smoothstep blend, square root and divide datapath.
// Depends on hnso_pkg.

// One transaction is accepted on any cycle where start is high; busy is always low,
// so a new phase can enter every clock. Each result appears on offset_x and offset_y
// with done high for exactly one cycle. The path from an accepted transaction to its
// result runs through the 32-step square root pipeline and the 16-step
// restoring divide pipeline. Results leave in the order transactions entered and the
// receiver must take them when they appear.
module hashed_noise_shake_offset_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        phase_step,
  input  logic [15:0]        phase_frac,
  input  logic [14:0]        amount,
  output logic               done,
  output logic signed [15:0] offset_x,
  output logic signed [15:0] offset_y
);

  localparam int FB = hnso_pkg::FRAC_BITS;
  localparam int SQN = hnso_pkg::SQRT_STEPS;
  localparam int DVN = hnso_pkg::DIV_STEPS;
  localparam logic [FB+1:0] THREE_ONE = (FB + 2)'(3) << FB;

  assign busy = 1'b0;

  // Stage 1: seeds and fraction.
  logic              v1;
  logic [31:0]       seed1 [4];
  logic [FB-1:0]     f1;
  logic [14:0]       amt1;
  logic [FB-1:0]     f_in;
  logic [31:0]       nxt;

  assign nxt = phase_step + 32'd1;

  generate
    if (FB >= 16) begin : g_fup
      assign f_in = FB'(phase_frac) << (FB - 16);
    end else begin : g_fdn
      assign f_in = FB'(phase_frac >> (16 - FB));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    seed1[0] <= {phase_step[30:0], 1'b0};
    seed1[1] <= {phase_step[30:0], 1'b1};
    seed1[2] <= {nxt[30:0], 1'b0};
    seed1[3] <= {nxt[30:0], 1'b1};
    f1 <= f_in;
    amt1 <= amount;
  end

  // Stages 2 to 5: hash and smoothstep.
  logic              v2, v3, v4, v5;
  logic [31:0]       h2 [4];
  logic [31:0]       t3 [4];
  logic [31:0]       r4 [4];
  logic signed [16:0] val5 [4];
  logic [2*FB-1:0]   ff2;
  logic [FB-1:0]     f2_3;
  logic [FB+1:0]     k3;
  logic [FB-1:0]     fc2;
  logic [2*FB+1:0]   bb4;
  logic [FB+1:0]     b5;
  logic [14:0]       amt2, amt3, amt4, amt5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    for (int i = 0; i < 4; i++) begin
      h2[i] <= 32'(seed1[i] * hnso_pkg::HASH_MUL) + hnso_pkg::HASH_ADD;
      t3[i] <= (h2[i] >> (h2[i][31:28] + 5'd4)) ^ h2[i];
      r4[i] <= 32'(t3[i] * hnso_pkg::HASH_MIX);
      val5[i] <= $signed({~r4[i][31], r4[i][30:15]});
    end
    ff2 <= f1 * f1;
    fc2 <= f1;
    f2_3 <= ff2[2*FB-1:FB];
    k3 <= THREE_ONE - {1'b0, fc2, 1'b0};
    bb4 <= (2*FB+2)'(f2_3 * k3);
    b5 <= bb4[2*FB+1:FB];
    amt2 <= amt1;
    amt3 <= amt2;
    amt4 <= amt3;
    amt5 <= amt4;
  end

  // Stages 6 to 9: blend, length squared.
  logic                 v6, v7, v8, v9;
  logic signed [FB+20:0] px6, py6;
  logic signed [16:0]   xa6, ya6;
  logic signed [17:0]   x7, y7, x8, y8;
  logic [33:0]          xx8, yy8;
  logic [34:0]          q9;
  logic [14:0]          amt6, amt7, amt8;
  logic [FB+20:0]       mpx, mpy;
  logic [17:0]          rx, ry;

  always_comb begin
    mpx = px6[FB+20] ? (FB+21)'(-px6) : (FB+21)'(px6);
    mpy = py6[FB+20] ? (FB+21)'(-py6) : (FB+21)'(py6);
    rx = 18'((mpx + ((FB+21)'(1) << (FB - 1))) >> FB);
    ry = 18'((mpy + ((FB+21)'(1) << (FB - 1))) >> FB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
    px6 <= (FB+21)'(($signed({val5[2][16], val5[2]}) - $signed({val5[0][16], val5[0]}))
           * $signed({1'b0, b5}));
    py6 <= (FB+21)'(($signed({val5[3][16], val5[3]}) - $signed({val5[1][16], val5[1]}))
           * $signed({1'b0, b5}));
    xa6 <= val5[0];
    ya6 <= val5[1];
    x7 <= {xa6[16], xa6} + (px6[FB+20] ? -$signed(rx) : $signed(rx));
    y7 <= {ya6[16], ya6} + (py6[FB+20] ? -$signed(ry) : $signed(ry));
    xx8 <= 34'(x7 * x7);
    yy8 <= 34'(y7 * y7);
    x8 <= x7;
    y8 <= y7;
    q9 <= {1'b0, xx8} + {1'b0, yy8};
    amt6 <= amt5;
    amt7 <= amt6;
    amt8 <= amt7;
  end

  logic signed [17:0] x9, y9;
  logic [14:0]        amt9;

  always_ff @(posedge clk) begin
    x9 <= x8;
    y9 <= y8;
    amt9 <= amt8;
  end

  // Square root pipeline: one result bit per stage.
  logic               sv  [SQN+1];
  logic [63:0]        srem [SQN+1];
  logic [63:0]        sres [SQN+1];
  logic signed [17:0] sx  [SQN+1];
  logic signed [17:0] sy  [SQN+1];
  logic [14:0]        samt [SQN+1];

  assign sv[0] = v9;
  assign srem[0] = {1'b0, q9, 28'd0};
  assign sres[0] = 64'd0;
  assign sx[0] = x9;
  assign sy[0] = y9;
  assign samt[0] = amt9;

  generate
    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      assign trial = sres[k] + BIT;
      always_ff @(posedge clk) begin
        if (rst) begin
          sv[k+1] <= 1'b0;
        end else begin
          sv[k+1] <= sv[k];
        end
        if (srem[k] >= trial) begin
          srem[k+1] <= srem[k] - trial;
          sres[k+1] <= (sres[k] >> 1) + BIT;
        end else begin
          srem[k+1] <= srem[k];
          sres[k+1] <= sres[k] >> 1;
        end
        sx[k+1] <= sx[k];
        sy[k+1] <= sy[k];
        samt[k+1] <= samt[k];
      end
    end
  endgenerate

  // Numerator forming.
  logic        va, vb;
  logic [31:0] mxa, mya;
  logic [31:0] la, lb;
  logic        nxa, nya, zra, nxb, nyb, zrb;
  logic [14:0] amta, amtb;
  logic [46:0] nxv, nyv;
  logic [16:0] ax, ay;

  assign ax = sx[SQN][17] ? 17'(-sx[SQN]) : 17'(sx[SQN]);
  assign ay = sy[SQN][17] ? 17'(-sy[SQN]) : 17'(sy[SQN]);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= sv[SQN];
      vb <= va;
    end
    mxa <= ax * samt[SQN];
    mya <= ay * samt[SQN];
    la <= sres[SQN][31:0];
    nxa <= sx[SQN][17];
    nya <= sy[SQN][17];
    zra <= (sx[SQN] == 18'sd0) && (sy[SQN] == 18'sd0);
    amta <= samt[SQN];
    nxv <= {1'b0, mxa, 14'd0} + 47'(la >> 1);
    nyv <= {1'b0, mya, 14'd0} + 47'(la >> 1);
    lb <= la;
    nxb <= nxa;
    nyb <= nya;
    zrb <= zra;
    amtb <= amta;
  end

  // Restoring divide pipeline: one quotient bit per stage on each axis.
  logic        dv   [DVN+1];
  logic [46:0] drx  [DVN+1];
  logic [46:0] dry  [DVN+1];
  logic [15:0] dqx  [DVN+1];
  logic [15:0] dqy  [DVN+1];
  logic [31:0] dl   [DVN+1];
  logic        dnx  [DVN+1];
  logic        dny  [DVN+1];
  logic        dz   [DVN+1];
  logic [14:0] damt [DVN+1];

  assign dv[0] = vb;
  assign drx[0] = nxv;
  assign dry[0] = nyv;
  assign dqx[0] = 16'd0;
  assign dqy[0] = 16'd0;
  assign dl[0] = lb;
  assign dnx[0] = nxb;
  assign dny[0] = nyb;
  assign dz[0] = zrb;
  assign damt[0] = amtb;

  generate
    for (genvar j = 0; j < DVN; j++) begin : g_div
      localparam int SH = DVN - 1 - j;
      logic [46:0] dvs;
      assign dvs = 47'(dl[j]) << SH;
      always_ff @(posedge clk) begin
        if (rst) begin
          dv[j+1] <= 1'b0;
        end else begin
          dv[j+1] <= dv[j];
        end
        if (drx[j] >= dvs) begin
          drx[j+1] <= drx[j] - dvs;
          dqx[j+1] <= dqx[j] | (16'd1 << SH);
        end else begin
          drx[j+1] <= drx[j];
          dqx[j+1] <= dqx[j];
        end
        if (dry[j] >= dvs) begin
          dry[j+1] <= dry[j] - dvs;
          dqy[j+1] <= dqy[j] | (16'd1 << SH);
        end else begin
          dry[j+1] <= dry[j];
          dqy[j+1] <= dqy[j];
        end
        dl[j+1] <= dl[j];
        dnx[j+1] <= dnx[j];
        dny[j+1] <= dny[j];
        dz[j+1] <= dz[j];
        damt[j+1] <= damt[j];
      end
    end
  endgenerate

  // Clamp, sign and output register.
  logic [15:0] cx, cy;

  always_comb begin
    cx = (dqx[DVN] > {1'b0, damt[DVN]}) ? {1'b0, damt[DVN]} : dqx[DVN];
    cy = (dqy[DVN] > {1'b0, damt[DVN]}) ? {1'b0, damt[DVN]} : dqy[DVN];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DVN];
    end
    if (dz[DVN]) begin
      offset_x <= 16'sd0;
      offset_y <= 16'sd0;
    end else begin
      offset_x <= dnx[DVN] ? -$signed(cx) : $signed(cx);
      offset_y <= dny[DVN] ? -$signed(cy) : $signed(cy);
    end
  end

endmodule
